FILE: src/fpba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_pkg - shared types for the fit-policy block allocator
// Policy codes and the control part of the search token that moves along
// the cell chain.
// ----------------------------------------------------------------------------
package fpba_pkg;

  // Placement rule; the unused code behaves as best fit.
  typedef enum logic [1:0] {
    POL_BEST  = 2'd0,
    POL_FIRST = 2'd1,
    POL_WORST = 2'd2
  } policy_t;

  // Control bits of the search token handed from cell to cell.
  typedef struct packed {
    logic valid;  // a search is at this position
    logic found;  // some earlier cell already holds a fitting block
  } tok_ctl_t;

endpackage

FILE: src/fpba_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_cell - one table entry of the allocator search chain
// Holds the free space of one block, takes writes addressed to it, and
// updates the passing search token when its block beats the current winner.
// ----------------------------------------------------------------------------
module fpba_cell import fpba_pkg::*; #(
  parameter int CELL_IDX  = 0,
  parameter int IDX_W     = 4,
  parameter int CNT_W     = 5,
  parameter int SIZE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           policy,
  input  logic [SIZE_BITS-1:0] req_size,
  input  logic [CNT_W-1:0]     limit,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_idx,
  input  logic [SIZE_BITS-1:0] wr_val,
  input  tok_ctl_t             tok_in,
  input  logic [IDX_W-1:0]     tok_in_pick,
  input  logic [SIZE_BITS-1:0] tok_in_rem,
  output tok_ctl_t             tok_out,
  output logic [IDX_W-1:0]     tok_out_pick,
  output logic [SIZE_BITS-1:0] tok_out_rem
);

  logic [SIZE_BITS-1:0] space_r;
  tok_ctl_t             tok_r;
  logic [IDX_W-1:0]     pick_r;
  logic [SIZE_BITS-1:0] rem_r;
  logic                 active;
  logic                 fits;
  logic                 better;
  logic                 take;

  assign active = CNT_W'(CELL_IDX) < limit;
  assign fits   = space_r >= req_size;

  // Both candidates fit, so comparing raw space orders leftovers too.
  always_comb begin
    case (policy)
      POL_FIRST: better = 1'b0;
      POL_WORST: better = space_r > tok_in_rem;
      default:   better = space_r < tok_in_rem;
    endcase
  end

  assign take = tok_in.valid && active && fits && (!tok_in.found || better);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_r     <= '0;
      tok_r.valid <= 1'b0;
      tok_r.found <= 1'b0;
    end else begin
      if (wr_en && (wr_idx == IDX_W'(CELL_IDX))) begin
        space_r <= wr_val;
      end
      tok_r.valid <= tok_in.valid;
      tok_r.found <= tok_in.found || take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pick_r <= IDX_W'(CELL_IDX);
      rem_r  <= space_r;
    end else begin
      pick_r <= tok_in_pick;
      rem_r  <= tok_in_rem;
    end
  end

  assign tok_out      = tok_r;
  assign tok_out_pick = pick_r;
  assign tok_out_rem  = rem_r;

endmodule

FILE: src/fit_policy_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator - best / first / worst fit block allocator
// A chain of cells holds the free space of each block; a request token
// walks the chain and picks the block under the selected placement rule.
// ----------------------------------------------------------------------------
// Usage: a transaction is taken when start is high and busy is low. A load
// transaction writes a block size and returns its result on the cycle after
// acceptance without raising busy, so loads can be issued back to back. A
// request transaction raises busy while the search token crosses all
// NUM_BLOCKS cells, one cell per clock, then commits the reduced space of
// the winner; busy drops in the same cycle that its result is on the ports,
// so the next transaction can be taken at the edge that ends the result
// cycle. A new request is not taken while one is in flight, and the length
// of the cell chain, not block_count, sets how long each one takes. Every
// result is shown for exactly one cycle with out_valid high; the receiver
// cannot stall, so it must capture each result when out_valid is seen.
// Configuration (policy, block_count) is written with cfg_we while idle.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator import fpba_pkg::*; #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [3:0]  in_block_index,
  input  logic [15:0] in_size,
  // result channel
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [3:0]  out_granted_block,
  output logic [15:0] out_space_left,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_wdata
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int LIM_W = (CNT_W > 5) ? CNT_W : 5;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_COUNT  = 1'b1;

  localparam logic [1:0] ST_LOADED = 2'd0;
  localparam logic [1:0] ST_ALLOC  = 2'd1;
  localparam logic [1:0] ST_NOFIT  = 2'd2;

  // Configuration registers
  logic [1:0]           policy_r;
  logic [4:0]           blk_cnt_r;
  logic [CNT_W-1:0]     limit;

  // Control
  logic                 accept;
  logic                 busy_r;
  logic                 inj_r;
  logic [SIZE_BITS-1:0] req_size_r;
  logic [SIZE_BITS-1:0] in_size_ext;
  logic                 load_in_range;

  // Cell write port
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic [SIZE_BITS-1:0] wr_val;

  // Search token chain; position 0 is the injection point.
  tok_ctl_t             tok_ctl  [NUM_BLOCKS+1];
  logic [IDX_W-1:0]     tok_pick [NUM_BLOCKS+1];
  logic [SIZE_BITS-1:0] tok_rem  [NUM_BLOCKS+1];

  tok_ctl_t             last_ctl;
  logic [SIZE_BITS-1:0] left_val;
  logic                 commit;

  // Result registers
  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [3:0]           out_block_r;
  logic [15:0]          out_left_r;

  assign accept        = start && !busy_r;
  assign in_size_ext   = SIZE_BITS'(in_size);
  assign load_in_range = 32'(in_block_index) < NUM_BLOCKS;

  // A count above the table size searches the whole table.
  assign limit = (LIM_W'(blk_cnt_r) > LIM_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                          : CNT_W'(blk_cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r  <= POL_BEST;
      blk_cnt_r <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLICY: policy_r  <= cfg_wdata[1:0];
        CFG_COUNT:  blk_cnt_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // Token injection
  assign tok_ctl[0]  = '{valid: inj_r, found: 1'b0};
  assign tok_pick[0] = '0;
  assign tok_rem[0]  = '0;

  assign last_ctl = tok_ctl[NUM_BLOCKS];
  assign commit   = last_ctl.valid && last_ctl.found;
  assign left_val = tok_rem[NUM_BLOCKS] - req_size_r;

  // Load writes happen only when idle; commits only while busy.
  always_comb begin
    if (commit) begin
      wr_en  = 1'b1;
      wr_idx = tok_pick[NUM_BLOCKS];
      wr_val = left_val;
    end else begin
      wr_en  = accept && (in_operation == OP_LOAD) && load_in_range;
      wr_idx = IDX_W'(in_block_index);
      wr_val = in_size_ext;
    end
  end

  genvar k;
  generate
    for (k = 0; k < NUM_BLOCKS; k++) begin : g_cell
      fpba_cell #(
        .CELL_IDX  (k),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W),
        .SIZE_BITS (SIZE_BITS)
      ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .policy       (policy_r),
        .req_size     (req_size_r),
        .limit        (limit),
        .wr_en        (wr_en),
        .wr_idx       (wr_idx),
        .wr_val       (wr_val),
        .tok_in       (tok_ctl[k]),
        .tok_in_pick  (tok_pick[k]),
        .tok_in_rem   (tok_rem[k]),
        .tok_out      (tok_ctl[k+1]),
        .tok_out_pick (tok_pick[k+1]),
        .tok_out_rem  (tok_rem[k+1])
      );
    end
  endgenerate

  // Control: busy covers a request from acceptance to commit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      inj_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      inj_r       <= accept && (in_operation == OP_REQUEST);
      out_valid_r <= (accept && (in_operation == OP_LOAD)) || last_ctl.valid;
      if (accept && (in_operation == OP_REQUEST)) begin
        busy_r <= 1'b1;
      end else if (last_ctl.valid) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_operation == OP_REQUEST)) begin
      req_size_r <= in_size_ext;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (last_ctl.valid) begin
      if (last_ctl.found) begin
        out_status_r <= ST_ALLOC;
        out_block_r  <= 4'(tok_pick[NUM_BLOCKS]);
        out_left_r   <= 16'(left_val);
      end else begin
        out_status_r <= ST_NOFIT;
        out_block_r  <= '0;
        out_left_r   <= '0;
      end
    end else if (accept && (in_operation == OP_LOAD)) begin
      out_status_r <= ST_LOADED;
      out_block_r  <= in_block_index;
      out_left_r   <= load_in_range ? 16'(in_size_ext) : 16'd0;
    end
  end

  assign busy              = busy_r;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_block = out_block_r;
  assign out_space_left    = out_left_r;

endmodule
